[rtl/core/sfl_pkg.sv]
// Shared constants, codes and control/status types for the sorted free-list pool allocator.
package sfl_pkg;

  localparam int POOL_CELLS = 1024;
  localparam int IDX_W      = $clog2(POOL_CELLS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int CNT_W      = 11;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_CELLS);

  localparam logic [1:0] CMD_ALLOC    = 2'd0;
  localparam logic [1:0] CMD_FREE     = 2'd1;
  localparam logic [1:0] CMD_FREE_ALL = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_EMPTY      = 2'd1;
  localparam logic [1:0] STAT_RANGE      = 2'd2;
  localparam logic [1:0] STAT_NOT_ALLOC  = 2'd3;

  localparam logic [CFG_AW-1:0] REG_CELL_COUNT = CFG_AW'(0);

  typedef struct packed {
    logic       capture;
    logic       fill_start;
    logic       fill_step;
    logic       fill_end;
    logic       rd_head;
    logic       walk_step;
    logic       alloc_pop;
    logic       push_empty;
    logic       push_front;
    logic       link_idx;
    logic       link_cur;
    logic       set_res;
    logic       res_ok;
    logic [1:0] res_status;
    logic       out_load;
  } sfl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       out_of_range;
    logic       below_head;
    logic       at_head;
    logic       walk_more;
    logic       walk_dup;
    logic       fill_last;
    logic       out_busy;
  } sfl_stat_t;

endpackage

[rtl/core/sfl_ctrl.sv]
// Controller state machine: sequences allocate, free, list walk and list rebuild.
module sfl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfl_pkg::sfl_stat_t stat,
  output sfl_pkg::sfl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DECODE   = 9'b000000100,
    S_ALLOC_RD = 9'b000001000,
    S_WALK     = 9'b000010000,
    S_LINK_IDX = 9'b000100000,
    S_LINK_CUR = 9'b001000000,
    S_FILL     = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT, S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          cmd.fill_end = 1'b1;
          state_nxt    = (state_r == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          sfl_pkg::CMD_ALLOC: begin
            if (stat.empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = sfl_pkg::STAT_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_ALLOC_RD;
            end
          end
          sfl_pkg::CMD_FREE: begin
            cmd.set_res = 1'b1;
            state_nxt   = S_RESP;
            if (stat.out_of_range) begin
              cmd.res_status = sfl_pkg::STAT_RANGE;
            end else if (stat.empty) begin
              cmd.push_empty = 1'b1;
              cmd.res_ok     = 1'b1;
            end else if (stat.below_head) begin
              cmd.push_front = 1'b1;
              cmd.res_ok     = 1'b1;
            end else if (stat.at_head) begin
              cmd.res_status = sfl_pkg::STAT_NOT_ALLOC;
            end else begin
              cmd.set_res = 1'b0;
              cmd.rd_head = 1'b1;
              state_nxt   = S_WALK;
            end
          end
          sfl_pkg::CMD_FREE_ALL: begin
            cmd.fill_start = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_ok     = 1'b1;
            state_nxt      = S_FILL;
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = sfl_pkg::STAT_RANGE;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_ALLOC_RD: begin
        cmd.alloc_pop = 1'b1;
        state_nxt     = S_RESP;
      end
      S_WALK: begin
        if (stat.walk_more) begin
          cmd.walk_step = 1'b1;
        end else if (stat.walk_dup) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = sfl_pkg::STAT_NOT_ALLOC;
          state_nxt      = S_RESP;
        end else begin
          cmd.link_idx = 1'b1;
          state_nxt    = S_LINK_CUR;
        end
      end
      S_LINK_IDX: begin
        cmd.link_idx = 1'b1;
        state_nxt    = S_LINK_CUR;
      end
      S_LINK_CUR: begin
        cmd.link_cur = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_ok   = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/sfl_dp.sv]
// Datapath: link memory, head and empty flag, walk pointer, count register and result word.
module sfl_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sfl_pkg::sfl_cmd_t           cmd,
  output sfl_pkg::sfl_stat_t          stat,
  input  logic                        cfg_we,
  input  logic [sfl_pkg::CNT_W-1:0]   cfg_wdata,
  output logic [sfl_pkg::CNT_W-1:0]   cell_count,
  input  logic [1:0]                  in_command,
  input  logic [sfl_pkg::IDX_W-1:0]   in_cell_index,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [sfl_pkg::IDX_W-1:0]   out_granted_index,
  output logic                        out_ok,
  output logic [1:0]                  out_status
);

  localparam int IDX_W  = sfl_pkg::IDX_W;
  localparam int LINK_W = sfl_pkg::LINK_W;
  localparam int CNT_W  = sfl_pkg::CNT_W;

  logic [LINK_W-1:0] link_mem [sfl_pkg::POOL_CELLS];

  logic [CNT_W-1:0]  cell_count_r, cell_count_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic              empty_r, empty_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [LINK_W-1:0] rd_data_r;
  logic [LINK_W-1:0] cnt_r, cnt_nxt;
  logic [LINK_W-1:0] lim_r, lim_nxt;
  logic [IDX_W-1:0]  res_granted_r, res_granted_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_granted_r, out_granted_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic [CNT_W-1:0]  eff_count;
  logic [LINK_W-1:0] idx_ext;
  logic [LINK_W-1:0] cnt_inc;
  logic              fill_last;
  logic              rd_null;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  // count saturated to 1..POOL_CELLS
  always_comb begin
    eff_count = cell_count_r;
    if (cell_count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (cell_count_r > CNT_W'(sfl_pkg::POOL_CELLS)) begin
      eff_count = CNT_W'(sfl_pkg::POOL_CELLS);
    end
  end

  assign idx_ext   = LINK_W'(idx_r);
  assign cnt_inc   = cnt_r + LINK_W'(1);
  assign fill_last = (cnt_inc == lim_r);
  assign rd_null   = (rd_data_r == sfl_pkg::NULL_LINK);

  assign stat.cmd          = cmd_r;
  assign stat.empty        = empty_r;
  assign stat.out_of_range = (CNT_W'(idx_r) >= eff_count);
  assign stat.below_head   = (idx_r < head_r);
  assign stat.at_head      = (idx_r == head_r);
  assign stat.walk_more    = !rd_null && (idx_ext > rd_data_r);
  assign stat.walk_dup     = (rd_data_r == idx_ext);
  assign stat.fill_last    = fill_last;
  assign stat.out_busy     = out_valid_r && !out_ready;

  // link memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = sfl_pkg::NULL_LINK;
    if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[IDX_W-1:0];
      mem_wdata = fill_last ? sfl_pkg::NULL_LINK : cnt_inc;
    end else if (cmd.push_empty) begin
      mem_we    = 1'b1;
    end else if (cmd.push_front) begin
      mem_we    = 1'b1;
      mem_wdata = LINK_W'(head_r);
    end else if (cmd.link_idx) begin
      mem_we    = 1'b1;
      mem_wdata = rd_data_r;
    end else if (cmd.link_cur) begin
      mem_we    = 1'b1;
      mem_waddr = cur_r;
      mem_wdata = idx_ext;
    end
  end

  assign mem_re    = cmd.rd_head || cmd.walk_step;
  assign mem_raddr = cmd.walk_step ? rd_data_r[IDX_W-1:0] : head_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= link_mem[mem_raddr];
    end
  end

  always_comb begin
    cell_count_nxt  = cfg_we ? cfg_wdata : cell_count_r;
    cmd_nxt         = cmd.capture ? in_command : cmd_r;
    idx_nxt         = cmd.capture ? in_cell_index : idx_r;
    head_nxt        = head_r;
    empty_nxt       = empty_r;
    cur_nxt         = cur_r;
    cnt_nxt         = cnt_r;
    lim_nxt         = lim_r;
    res_granted_nxt = res_granted_r;
    res_ok_nxt      = res_ok_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_granted_nxt = out_granted_r;
    out_ok_nxt      = out_ok_r;
    out_status_nxt  = out_status_r;

    if (cmd.fill_start) begin
      cnt_nxt = '0;
      lim_nxt = LINK_W'(eff_count);
    end
    if (cmd.fill_step) begin
      cnt_nxt = cnt_inc;
    end
    if (cmd.fill_end) begin
      head_nxt  = '0;
      empty_nxt = 1'b0;
    end
    if (cmd.rd_head) begin
      cur_nxt = head_r;
    end
    if (cmd.walk_step) begin
      cur_nxt = rd_data_r[IDX_W-1:0];
    end
    if (cmd.push_empty || cmd.push_front) begin
      head_nxt  = idx_r;
      empty_nxt = 1'b0;
    end
    if (cmd.alloc_pop) begin
      res_granted_nxt = head_r;
      res_ok_nxt      = 1'b1;
      res_status_nxt  = sfl_pkg::STAT_OK;
      empty_nxt       = rd_null;
      head_nxt        = rd_null ? '0 : rd_data_r[IDX_W-1:0];
    end
    if (cmd.set_res) begin
      res_granted_nxt = '0;
      res_ok_nxt      = cmd.res_ok;
      res_status_nxt  = cmd.res_status;
    end
    if (cmd.out_load) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = res_granted_r;
      out_ok_nxt      = res_ok_r;
      out_status_nxt  = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= CNT_W'(sfl_pkg::POOL_CELLS);
      head_r       <= '0;
      empty_r      <= 1'b0;
      cnt_r        <= '0;
      lim_r        <= LINK_W'(sfl_pkg::POOL_CELLS);
      out_valid_r  <= 1'b0;
    end else begin
      cell_count_r <= cell_count_nxt;
      head_r       <= head_nxt;
      empty_r      <= empty_nxt;
      cnt_r        <= cnt_nxt;
      lim_r        <= lim_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    idx_r         <= idx_nxt;
    cur_r         <= cur_nxt;
    res_granted_r <= res_granted_nxt;
    res_ok_r      <= res_ok_nxt;
    res_status_r  <= res_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_ok_r      <= out_ok_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign cell_count        = cell_count_r;
  assign out_valid         = out_valid_r;
  assign out_granted_index = out_granted_r;
  assign out_ok            = out_ok_r;
  assign out_status        = out_status_r;

endmodule

[rtl/core/sorted_free_list_pool_allocator.sv]
// Top level of the sorted free-list pool allocator: APB register port, controller and datapath.
//
//   channel  | ports                                     | word accepted when
//   ---------+-------------------------------------------+-----------------------------
//   in       | in_command, in_cell_index                 | in_valid && in_ready
//   out      | out_granted_index, out_ok, out_status     | out_valid && out_ready
//   cfg      | psel, penable, pwrite, paddr, pwdata ...  | psel && penable && pwrite
//
// One word at a time. Free may walk links of the sorted list, also when the cell
// is already free; one link memory read per cycle. Free all rebuilds the list,
// one link written per cycle. After reset a rebuild pass over all 1024 cells
// runs with in_ready low. A result waiting in the output register does not
// stop the next word from being accepted and worked up to its result.
module sorted_free_list_pool_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic [sfl_pkg::IDX_W-1:0]    in_cell_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sfl_pkg::IDX_W-1:0]    out_granted_index,
  output logic                         out_ok,
  output logic [1:0]                   out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfl_pkg::CFG_AW-1:0]   paddr,
  input  logic [sfl_pkg::CFG_DW-1:0]   pwdata,
  output logic [sfl_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  sfl_pkg::sfl_cmd_t           cmd;
  sfl_pkg::sfl_stat_t          stat;
  logic                        reg_hit;
  logic                        cfg_we;
  logic [sfl_pkg::CNT_W-1:0]   cell_count;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[sfl_pkg::CFG_AW-1] == sfl_pkg::REG_CELL_COUNT[sfl_pkg::CFG_AW-1]);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? sfl_pkg::CFG_DW'(cell_count) : '0;

  sfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (pwdata[sfl_pkg::CNT_W-1:0]),
    .cell_count        (cell_count),
    .in_command        (in_command),
    .in_cell_index     (in_cell_index),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_granted_index (out_granted_index),
    .out_ok            (out_ok),
    .out_status        (out_status)
  );

endmodule

[rtl/core/sfl_checker.sv]
// Port-level checker for the pool allocator, bound to the top level.
module sfl_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sfl_pkg::IDX_W-1:0] out_granted_index,
  input logic                      out_ok,
  input logic [1:0]                out_status
);

  // rebuild pass holds off input right after reset
  a_init_blocks: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input accepted during rebuild pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_granted_index)
      && $stable(out_ok) && $stable(out_status)))
    else $error("stalled result word changed");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok == (out_status == sfl_pkg::STAT_OK)))
    else $error("ok flag disagrees with status");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_granted_index == '0))
    else $error("failed command reports a granted cell");

endmodule

bind sorted_free_list_pool_allocator sfl_checker u_sfl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_granted_index (out_granted_index),
  .out_ok            (out_ok),
  .out_status        (out_status)
);
